>>> rtl/cokl_pkg.sv
package cokl_pkg;

    // Sizing of the list store
    localparam int CAPACITY     = 64;
    localparam int ID_BITS      = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int MEM_W   = ID_BITS + PAYLOAD_BITS;

    // Fixed port field widths
    localparam int CMD_W     = 3;
    localparam int KEY_W     = 16;
    localparam int PAY_W     = 32;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 7;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 56;

    // Width for index arithmetic and position compare
    localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_NEXT   = 3'd3,
        CMD_PREV   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Read address source
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_POS,
        RD_IDX1,
        RD_IDX2,
        RD_NBR
    } rd_sel_t;

    // Write address and data source
    typedef enum logic {
        WR_APPEND,
        WR_SHIFT
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    len_inc;
        logic    len_dec;
        logic    out_load;
        status_t out_status;
        logic    out_use_data;
    } dp_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic pos_ok;
        logic match;
        logic last;
        logic shift_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/circular_ordered_keyed_list_top.sv
// Channel  | Dir | tdata (low bit up)                        | tuser
// s_axis   | in  | key_id[15:0] entry_payload[31:0] position[5:0] | cmd[2:0]
// m_axis   | out | result_id[15:0] result_payload[31:0] entry_count[6:0] | status[1:0]
//
// One request at a time; the result sits in an output register, so the next
// request is taken while a result still waits on m_axis.
// Append, get and the empty or unknown-command answers go from decode straight
// to the result register; next/previous scan the list up to the hit, and remove
// and a search that misses walk the whole list. The single read port of the
// entry store, walking one entry per cycle, sets the scan time; s_axis_tready
// returns the cycle after the result is loaded.
// Reset clears the length and control; stored entries are not cleared.
// m_axis stalls hold the result; the next result waits until it is taken.
module circular_ordered_keyed_list_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // key_id, entry_payload, position, zero pad
    input  logic [cokl_pkg::S_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [cokl_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_id, result_payload, entry_count, zero pad
    output logic [cokl_pkg::M_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [cokl_pkg::STAT_W-1:0]   m_axis_tuser
);
    import cokl_pkg::*;

    dp_ctrl_t           ctrl;
    dp_stat_t           stat;
    logic [KEY_W-1:0]   out_id;
    logic [PAY_W-1:0]   out_payload;
    logic [COUNT_W-1:0] out_count;

    cokl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    cokl_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .in_cmd      (s_axis_tuser),
        .in_key      (s_axis_tdata[KEY_W-1:0]),
        .in_payload  (s_axis_tdata[KEY_W +: PAY_W]),
        .in_pos      (s_axis_tdata[KEY_W + PAY_W +: POS_W]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_status  (m_axis_tuser),
        .out_id      (out_id),
        .out_payload (out_payload),
        .out_count   (out_count)
    );

    // Pack result fields, zero pad to whole bytes
    assign m_axis_tdata = {{(M_DATA_W - KEY_W - PAY_W - COUNT_W){1'b0}},
                           out_count, out_payload, out_id};

endmodule

>>> rtl/cokl_ram.sv
module cokl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/cokl_datapath.sv
module cokl_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cokl_pkg::dp_ctrl_t               ctrl,
    output cokl_pkg::dp_stat_t               stat,
    input  logic [cokl_pkg::CMD_W-1:0]       in_cmd,
    input  logic [cokl_pkg::KEY_W-1:0]       in_key,
    input  logic [cokl_pkg::PAY_W-1:0]       in_payload,
    input  logic [cokl_pkg::POS_W-1:0]       in_pos,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [cokl_pkg::STAT_W-1:0]      out_status,
    output logic [cokl_pkg::KEY_W-1:0]       out_id,
    output logic [cokl_pkg::PAY_W-1:0]       out_payload,
    output logic [cokl_pkg::COUNT_W-1:0]     out_count
);
    import cokl_pkg::*;

    cmd_t                    cmd_reg;
    logic [ID_BITS-1:0]      key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [CNT_W-1:0]        len_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [KEY_W-1:0]        out_id_reg;
    logic [PAY_W-1:0]        out_pay_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic [CMP_W-1:0]        idx_w;
    logic [CMP_W-1:0]        len_w;
    logic [CMP_W-1:0]        nbr_w;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic [MEM_W-1:0]        wr_data;
    logic [MEM_W-1:0]        rd_data;
    logic [ID_BITS-1:0]      rd_id;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    out_free;

    assign idx_w  = CMP_W'(idx_reg);
    assign len_w  = CMP_W'(len_reg);
    assign rd_id  = rd_data[MEM_W-1 -: ID_BITS];
    assign rd_pay = rd_data[PAYLOAD_BITS-1:0];
    assign out_free = !out_valid_reg || out_ready;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= cmd_t'(in_cmd);
            key_reg <= ID_BITS'(in_key);
            pay_reg <= PAYLOAD_BITS'(in_payload);
            pos_reg <= in_pos;
        end
    end

    // Scan index and list length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            if (ctrl.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctrl.len_inc)
            begin
                len_reg <= len_reg + 1'b1;
            end
            else if (ctrl.len_dec)
            begin
                len_reg <= len_reg - 1'b1;
            end
        end
    end

    // Neighbor of the hit entry, wrapping at both ends
    always_comb
    begin
        if (cmd_reg == CMD_NEXT)
        begin
            nbr_w = (idx_w + 1'b1 == len_w) ? '0 : idx_w + 1'b1;
        end
        else
        begin
            nbr_w = (idx_reg == '0) ? len_w - 1'b1 : idx_w - 1'b1;
        end
    end

    // Read address select
    always_comb
    begin
        case (ctrl.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_POS:  rd_addr = ADDR_W'(pos_reg);
            RD_IDX1: rd_addr = ADDR_W'(idx_w + 1'b1);
            RD_IDX2: rd_addr = ADDR_W'(idx_w + 2'd2);
            RD_NBR:  rd_addr = ADDR_W'(nbr_w);
            default: rd_addr = '0;
        endcase
    end

    // Write select: append at the tail or shift one entry down
    always_comb
    begin
        if (ctrl.wr_sel == WR_APPEND)
        begin
            wr_addr = ADDR_W'(len_reg);
            wr_data = {key_reg, pay_reg};
        end
        else
        begin
            wr_addr = idx_reg;
            wr_data = rd_data;
        end
    end

    cokl_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Status toward the controller
    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.full       = (len_reg == CNT_W'(CAPACITY));
        stat.empty      = (len_reg == '0);
        stat.pos_ok     = (CMP_W'(pos_reg) < len_w);
        stat.match      = (rd_id == key_reg);
        stat.last       = (idx_w + 1'b1 == len_w);
        stat.shift_last = (idx_w + 2'd2 == len_w);
        stat.out_free   = out_free;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_status_reg <= ctrl.out_status;
            out_count_reg  <= COUNT_W'(len_reg);
            out_id_reg     <= ctrl.out_use_data ? KEY_W'(rd_id) : '0;
            out_pay_reg    <= ctrl.out_use_data ? PAY_W'(rd_pay) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_id      = out_id_reg;
    assign out_payload = out_pay_reg;
    assign out_count   = out_count_reg;

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_no_inc_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.len_inc |-> !stat.full)
        else $error("append grew a full list");

    a_no_dec_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.len_dec |-> !stat.empty)
        else $error("remove shrank an empty list");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> out_free)
        else $error("result overwritten before it was taken");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> rtl/cokl_ctrl.sv
module cokl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cokl_pkg::dp_stat_t   stat,
    output cokl_pkg::dp_ctrl_t   ctrl
);
    import cokl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    use_data_reg, use_data_next;

    // State and registered result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            status_reg   <= ST_OK;
            use_data_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            use_data_reg <= use_data_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next        = state_reg;
        status_next       = status_reg;
        use_data_next     = use_data_reg;
        in_ready          = 1'b0;
        ctrl              = '0;
        ctrl.rd_sel       = RD_IDX1;
        ctrl.wr_sel       = WR_SHIFT;
        ctrl.out_status   = status_reg;
        ctrl.out_use_data = use_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                use_data_next = 1'b0;
                state_next    = S_DONE;
                unique case (stat.cmd) inside
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_sel  = WR_APPEND;
                            ctrl.len_inc = 1'b1;
                            status_next  = ST_OK;
                        end
                    end
                    CMD_GET:
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (stat.pos_ok)
                        begin
                            ctrl.rd_en    = 1'b1;
                            ctrl.rd_sel   = RD_POS;
                            status_next   = ST_OK;
                            use_data_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_REMOVE, CMD_NEXT, CMD_PREV:
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.rd_en   = 1'b1;
                            ctrl.rd_sel  = RD_ZERO;
                            ctrl.idx_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                endcase
            end

            // One stored entry compared per cycle, next one read ahead
            S_SCAN:
            begin
                ctrl.rd_en = 1'b1;
                if (stat.match)
                begin
                    if (stat.cmd == CMD_REMOVE)
                    begin
                        if (stat.last)
                        begin
                            ctrl.len_dec  = 1'b1;
                            status_next   = ST_OK;
                            use_data_next = 1'b0;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        ctrl.rd_sel   = RD_NBR;
                        status_next   = ST_OK;
                        use_data_next = 1'b1;
                        state_next    = S_DONE;
                    end
                end
                else if (stat.last)
                begin
                    status_next   = ST_NOT_FOUND;
                    use_data_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end

            // Close the gap: entry idx+1 moves to idx
            S_SHIFT:
            begin
                ctrl.wr_en = 1'b1;
                if (stat.shift_last)
                begin
                    ctrl.len_dec  = 1'b1;
                    status_next   = ST_OK;
                    use_data_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    ctrl.rd_en   = 1'b1;
                    ctrl.rd_sel  = RD_IDX2;
                    ctrl.idx_inc = 1'b1;
                end
            end

            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("request taken while busy");

    a_no_rw_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> !ctrl.rd_en && !ctrl.wr_en)
        else $error("store accessed while result pending");

    a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> state_reg == S_DECODE)
        else $error("captured request not decoded");

endmodule

>>> test/tb_circular_ordered_keyed_list_top.sv
module tb_circular_ordered_keyed_list_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cokl_pkg::*;

    // Command codes outside the defined set; the block answers not found
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 1600;
    localparam int IDLE_PCT   = 18;
    localparam int DRAIN_WAIT = 80;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   rid;
        logic [PAY_W-1:0]   rpay;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic [POS_W-1:0] pos;
        bit               known;
        list_result_t     exp;
    } dir_row_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]    s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]   m_axis_tuser;

    // Shadow copy of the list contents
    logic [KEY_W-1:0] shadow_ids  [CAPACITY];
    logic [PAY_W-1:0] shadow_pays [CAPACITY];
    int               shadow_len;

    list_result_t pending_results [$];
    int           errors        = 0;
    int           requests_sent = 0;
    bit           no_idle       = 1'b0;

    // Directed requests: fixed results where they follow from reset or extremes
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, '0, '0, 7'd0}},
        '{CMD_GET,    16'h0000, 32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, '0, '0, 7'd0}},
        '{CMD_NEXT,   16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_EMPTY, '0, '0, 7'd0}},
        '{CMD_PREV,   16'h0000, 32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, '0, '0, 7'd0}},
        '{CMD_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_OK, '0, '0, 7'd1}},
        '{CMD_NEXT,   16'hFFFF, 32'h0000_0000, 6'd0,  1'b1,
          '{ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 7'd1}},
        '{CMD_PREV,   16'hFFFF, 32'h0000_0000, 6'd0,  1'b1,
          '{ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 7'd1}},
        '{CMD_GET,    16'h0000, 32'h0000_0000, 6'd0,  1'b1,
          '{ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 7'd1}},
        '{CMD_GET,    16'h0000, 32'h0000_0000, 6'd63, 1'b1, '{ST_NOT_FOUND, '0, '0, 7'd1}},
        '{CMD_GET,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{ST_NOT_FOUND, '0, '0, 7'd1}},
        '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 6'd0,  1'b1, '{ST_NOT_FOUND, '0, '0, 7'd1}},
        '{CMD_RSVD_5, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_NOT_FOUND, '0, '0, 7'd1}},
        '{CMD_RSVD_6, 16'hFFFF, 32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_NOT_FOUND, '0, '0, 7'd1}},
        '{CMD_RSVD_7, 16'h0000, 32'h0000_0000, 6'd0,  1'b1, '{ST_NOT_FOUND, '0, '0, 7'd1}},
        '{CMD_APPEND, 16'h0000, 32'h0000_0000, 6'd0,  1'b1, '{ST_OK, '0, '0, 7'd2}},
        '{CMD_APPEND, 16'hFFFF, 32'h1234_5678, 6'd5,  1'b1, '{ST_OK, '0, '0, 7'd3}},
        '{CMD_NEXT,   16'hFFFF, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{CMD_PREV,   16'h0000, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{CMD_PREV,   16'hFFFF, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{CMD_APPEND, 16'h5A5A, 32'hA5A5_A5A5, 6'd42, 1'b0, '0},
        '{CMD_NEXT,   16'h5A5A, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{CMD_REMOVE, 16'hFFFF, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{CMD_GET,    16'h0000, 32'h0000_0000, 6'd2,  1'b0, '0},
        '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{CMD_REMOVE, 16'hFFFF, 32'h0000_0000, 6'd0,  1'b0, '0}
    };

    circular_ordered_keyed_list_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Apply one command to the shadow list and return what the block should answer
    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                    logic [KEY_W-1:0] key,
                                                    logic [PAY_W-1:0] pay,
                                                    logic [POS_W-1:0] pos);
        list_result_t r;
        int hit;
        int nb;
        r = '0;
        r.status = ST_NOT_FOUND;
        hit = -1;
        if (cmd == CMD_REMOVE || cmd == CMD_NEXT || cmd == CMD_PREV)
        begin
            for (int i = 0; i < shadow_len; i++)
            begin
                if (hit < 0 && shadow_ids[i] == key)
                    hit = i;
            end
        end
        case (cmd)
            CMD_APPEND:
            begin
                if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_ids[shadow_len]  = key;
                    shadow_pays[shadow_len] = pay;
                    shadow_len++;
                    r.status = ST_OK;
                end
            end
            CMD_REMOVE:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (hit >= 0)
                begin
                    // close the gap, keeping order
                    for (int i = hit; i + 1 < shadow_len; i++)
                    begin
                        shadow_ids[i]  = shadow_ids[i+1];
                        shadow_pays[i] = shadow_pays[i+1];
                    end
                    shadow_len--;
                    r.status = ST_OK;
                end
            end
            CMD_GET:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(pos) < shadow_len)
                begin
                    r.rid    = shadow_ids[pos];
                    r.rpay   = shadow_pays[pos];
                    r.status = ST_OK;
                end
            end
            CMD_NEXT, CMD_PREV:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (hit >= 0)
                begin
                    // neighbor wraps around both ends
                    if (cmd == CMD_NEXT)
                        nb = (hit + 1) % shadow_len;
                    else
                        nb = (hit + shadow_len - 1) % shadow_len;
                    r.rid    = shadow_ids[nb];
                    r.rpay   = shadow_pays[nb];
                    r.status = ST_OK;
                end
            end
            default:
                r.status = ST_NOT_FOUND;
        endcase
        r.count = shadow_len[COUNT_W-1:0];
        return r;
    endfunction

    // Mostly ids already stored, then a small pool for collisions and ids near all ones, else any id
    function automatic logic [KEY_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && shadow_len > 0)
            return shadow_ids[$urandom_range(0, shadow_len - 1)];
        else if (r < 75)
            return KEY_W'($urandom_range(0, 15));
        else if (r < 80)
            return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
        return KEY_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 99) < 75 && shadow_len > 0)
            return POS_W'($urandom_range(0, shadow_len - 1));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // Drive one request, wait for its accept, queue its expected result
    task automatic issue_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos,
                                 bit known, list_result_t exp);
        list_result_t pred;
        no_idle = (requests_sent >= N_DIRECTED + 700) &&
                  (requests_sent <  N_DIRECTED + 1000);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pos, pay, key};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = apply_list_cmd(cmd, key, pay, pos);
        pending_results.push_back(known ? exp : pred);
        requests_sent++;
    endtask

    task automatic random_request(logic [CMD_W-1:0] cmd);
        issue_request(cmd, pick_id(), $urandom, pick_pos(), 1'b0, '0);
    endtask

    // Receiver backpressure
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    // Result checker
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tuser);
            got.rid    = m_axis_tdata[15:0];
            got.rpay   = m_axis_tdata[47:16];
            got.count  = m_axis_tdata[54:48];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d id %h count %0d",
                       got.status, got.rid, got.count);
                errors++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, got.status);
                    errors++;
                end
                if (got.rid !== exp.rid)
                begin
                    $error("result_id: expected %h, got %h", exp.rid, got.rid);
                    errors++;
                end
                if (got.rpay !== exp.rpay)
                begin
                    $error("result_payload: expected %h, got %h", exp.rpay, got.rpay);
                    errors++;
                end
                if (got.count !== exp.count)
                begin
                    $error("entry_count: expected %0d, got %0d", exp.count, got.count);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int kind;
        int ops;
        int r;
        shadow_len = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].cmd, directed_rows[i].key,
                          directed_rows[i].pay, directed_rows[i].pos,
                          directed_rows[i].known, directed_rows[i].exp);

        while (requests_sent < N_DIRECTED + N_RANDOM)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                // fill to capacity, then push past it
                while (shadow_len < CAPACITY)
                begin
                    if ($urandom_range(0, 9) == 0)
                        random_request($urandom_range(0, 1) ? CMD_GET : CMD_NEXT);
                    else
                        random_request(CMD_APPEND);
                end
                ops = $urandom_range(1, 3);
                repeat (ops) random_request(CMD_APPEND);
                random_request(CMD_PREV);
            end
            else if (kind < 35)
            begin
                // drain to empty, then poke the empty list
                while (shadow_len > 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        issue_request(CMD_REMOVE,
                                      shadow_ids[$urandom_range(0, shadow_len - 1)],
                                      $urandom, POS_W'($urandom), 1'b0, '0);
                    else if (r < 92)
                        random_request(CMD_REMOVE);
                    else
                        random_request(CMD_GET);
                end
                random_request(CMD_REMOVE);
                random_request($urandom_range(0, 1) ? CMD_NEXT : CMD_PREV);
                random_request(CMD_GET);
            end
            else
            begin
                // mixed traffic
                ops = $urandom_range(20, 60);
                repeat (ops)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        random_request(CMD_APPEND);
                    else if (r < 50)
                        random_request(CMD_REMOVE);
                    else if (r < 68)
                        random_request(CMD_GET);
                    else if (r < 81)
                        random_request(CMD_NEXT);
                    else if (r < 94)
                        random_request(CMD_PREV);
                    else
                        issue_request(CMD_W'($urandom_range(5, 7)), KEY_W'($urandom),
                                      $urandom, POS_W'($urandom), 1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> circular_ordered_keyed_list_top.f
rtl/cokl_pkg.sv
rtl/cokl_ram.sv
rtl/cokl_datapath.sv
rtl/cokl_ctrl.sv
rtl/circular_ordered_keyed_list_top.sv
test/tb_circular_ordered_keyed_list_top.sv
